### rtl/core/usc_pkg.sv
// ----------------------------------------------------------------------------
// usc_pkg
// Shared types, codes and helpers for the URL suffix type classifier.
// ----------------------------------------------------------------------------
package usc_pkg;

	// Fixed field widths
	localparam int CHAR_W     = 8;
	localparam int LEN_W      = 4;
	localparam int TYPE_W     = 8;
	localparam int KEY_PORT_W = 64;
	localparam int INDEX_W    = 4;
	localparam int STATUS_W   = 2;

	// Request opcodes
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_CHAR  = 2'd2;
	localparam logic [1:0] OP_END   = 2'd3;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

	// Characters that steer suffix tracking
	localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;

	// Controller states
	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic add;
		logic clear;
		logic take_char;
		logic begin_scan;
		logic issue;
		logic finish;
	} ctrl_t;

	// Datapath to controller status
	typedef struct packed {
		logic more;
		logic hit;
		logic exhausted;
	} stat_t;

	// Fold lower-case ASCII letters to upper case
	function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if ((c >= 8'h61) && (c <= 8'h7A)) begin
			r = c - 8'h20;
		end
		return r;
	endfunction

endpackage

### rtl/core/usc_ram.sv
// ----------------------------------------------------------------------------
// usc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module usc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/usc_datapath.sv
// ----------------------------------------------------------------------------
// usc_datapath
// Suffix tracking, entry table, sequential lookup scan and result registers.
// ----------------------------------------------------------------------------
module usc_datapath #(
	parameter int TABLE_DEPTH = 16,
	parameter int KEY_CHARS   = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  usc_pkg::ctrl_t                      ctrl,
	output usc_pkg::stat_t                      stat,
	input  logic [usc_pkg::CHAR_W-1:0]          url_char,
	input  logic [usc_pkg::KEY_PORT_W-1:0]      entry_key,
	input  logic [usc_pkg::LEN_W-1:0]           entry_len,
	input  logic [usc_pkg::TYPE_W-1:0]          entry_type,
	input  logic                                cfg_valid,
	input  logic [usc_pkg::TYPE_W-1:0]          cfg_data,
	output logic                                done,
	output logic [usc_pkg::STATUS_W-1:0]        status,
	output logic [usc_pkg::TYPE_W-1:0]          type_code,
	output logic [usc_pkg::INDEX_W-1:0]         match_index
);

	localparam int KEY_W  = KEY_CHARS * usc_pkg::CHAR_W;
	localparam int WORD_W = KEY_W + usc_pkg::LEN_W + usc_pkg::TYPE_W;
	localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int EXT_W  = CNT_W + usc_pkg::INDEX_W;
	localparam logic [usc_pkg::LEN_W-1:0] KEY_LEN_MAX = usc_pkg::LEN_W'(KEY_CHARS);

	// Configuration and table fill state
	logic [usc_pkg::TYPE_W-1:0] unknown_q;
	logic [CNT_W-1:0]           count_q;

	// Suffix tracking
	logic [KEY_W-1:0]           sfx_buf_q;
	logic [usc_pkg::LEN_W-1:0]  sfx_len_q;
	logic                       sfx_ovf_q;
	logic                       dot_q;

	// Scan pointer and read stage
	logic [CNT_W-1:0]           scan_idx_q;
	logic                       pend_s1;
	logic [CNT_W-1:0]           idx_s1;

	// Result registers
	logic                       done_q;
	logic [usc_pkg::STATUS_W-1:0] status_q;
	logic [usc_pkg::TYPE_W-1:0] type_q;
	logic [usc_pkg::INDEX_W-1:0] index_q;

	logic                       full;
	logic [usc_pkg::LEN_W-1:0]  len_sat;
	logic [KEY_W-1:0]           key_masked;
	logic [KEY_W-1:0]           sfx_appended;
	logic [WORD_W-1:0]          wr_word;
	logic [WORD_W-1:0]          rd_word;
	logic [KEY_W-1:0]           rd_key;
	logic [usc_pkg::LEN_W-1:0]  rd_len;
	logic [usc_pkg::TYPE_W-1:0] rd_type;
	logic                       key_eq;
	logic                       eligible;
	logic [EXT_W-1:0]           add_idx_ext;
	logic [EXT_W-1:0]           hit_idx_ext;

	assign full     = (count_q == CNT_W'(TABLE_DEPTH));
	assign eligible = dot_q && !sfx_ovf_q;
	assign len_sat  = (entry_len > KEY_LEN_MAX) ? KEY_LEN_MAX : entry_len;

	// Zero key bytes beyond the entry length
	always_comb begin
		for (int k = 0; k < KEY_CHARS; k++) begin
			if (usc_pkg::LEN_W'(k) < len_sat) begin
				key_masked[k*usc_pkg::CHAR_W +: usc_pkg::CHAR_W] =
					entry_key[k*usc_pkg::CHAR_W +: usc_pkg::CHAR_W];
			end else begin
				key_masked[k*usc_pkg::CHAR_W +: usc_pkg::CHAR_W] = '0;
			end
		end
	end

	// Place the incoming byte at the current suffix length
	always_comb begin
		sfx_appended = sfx_buf_q;
		for (int k = 0; k < KEY_CHARS; k++) begin
			if (usc_pkg::LEN_W'(k) == sfx_len_q) begin
				sfx_appended[k*usc_pkg::CHAR_W +: usc_pkg::CHAR_W] = url_char;
			end
		end
	end

	assign wr_word = {entry_type, len_sat, key_masked};

	// Entry table
	usc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ctrl.add && !full),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wr_word),
		.raddr (scan_idx_q[IDX_W-1:0]),
		.rdata (rd_word)
	);

	assign rd_key  = rd_word[KEY_W-1:0];
	assign rd_len  = rd_word[KEY_W +: usc_pkg::LEN_W];
	assign rd_type = rd_word[KEY_W + usc_pkg::LEN_W +: usc_pkg::TYPE_W];

	// Case-blind compare; bytes past the length are zero on both sides
	always_comb begin
		key_eq = (rd_len == sfx_len_q);
		for (int k = 0; k < KEY_CHARS; k++) begin
			if (usc_pkg::fold(rd_key[k*usc_pkg::CHAR_W +: usc_pkg::CHAR_W]) !=
				usc_pkg::fold(sfx_buf_q[k*usc_pkg::CHAR_W +: usc_pkg::CHAR_W])) begin
				key_eq = 1'b0;
			end
		end
	end

	// Report scan progress
	assign stat.more      = eligible && (scan_idx_q < count_q);
	assign stat.hit       = pend_s1 && key_eq;
	assign stat.exhausted = !stat.more && !pend_s1;

	assign add_idx_ext = EXT_W'(count_q);
	assign hit_idx_ext = EXT_W'(idx_s1);

	// Hold the unknown code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unknown_q <= '0;
		end else if (cfg_valid) begin
			unknown_q <= cfg_data;
		end
	end

	// Advance or drop the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.clear) begin
			count_q <= '0;
		end else if (ctrl.add && !full) begin
			count_q <= count_q + 1'b1;
		end
	end

	// Track the text after the last dot of the last path segment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sfx_buf_q <= '0;
			sfx_len_q <= '0;
			sfx_ovf_q <= 1'b0;
			dot_q     <= 1'b0;
		end else if (ctrl.finish) begin
			sfx_buf_q <= '0;
			sfx_len_q <= '0;
			sfx_ovf_q <= 1'b0;
			dot_q     <= 1'b0;
		end else if (ctrl.take_char) begin
			case (url_char) inside
				usc_pkg::CH_SLASH, usc_pkg::CH_BSLASH, usc_pkg::CH_COLON: begin
					sfx_buf_q <= '0;
					sfx_len_q <= '0;
					sfx_ovf_q <= 1'b0;
					dot_q     <= 1'b0;
				end
				usc_pkg::CH_DOT: begin
					sfx_buf_q <= '0;
					sfx_len_q <= '0;
					sfx_ovf_q <= 1'b0;
					dot_q     <= 1'b1;
				end
				default: begin
					if (dot_q) begin
						if (sfx_len_q < KEY_LEN_MAX) begin
							sfx_buf_q <= sfx_appended;
							sfx_len_q <= sfx_len_q + 1'b1;
						end else begin
							sfx_ovf_q <= 1'b1;
						end
					end
				end
			endcase
		end
	end

	// Step the scan pointer and the read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			pend_s1    <= 1'b0;
		end else begin
			pend_s1 <= ctrl.issue;
			if (ctrl.begin_scan) begin
				scan_idx_q <= '0;
			end else if (ctrl.issue) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q;
	end

	// Strobe a result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.add || ctrl.clear || ctrl.finish;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (ctrl.add) begin
			if (full) begin
				status_q <= usc_pkg::STAT_FULL;
				type_q   <= '0;
				index_q  <= '0;
			end else begin
				status_q <= usc_pkg::STAT_OK;
				type_q   <= entry_type;
				index_q  <= add_idx_ext[usc_pkg::INDEX_W-1:0];
			end
		end else if (ctrl.clear) begin
			status_q <= usc_pkg::STAT_OK;
			type_q   <= '0;
			index_q  <= '0;
		end else if (ctrl.finish) begin
			if (stat.hit) begin
				status_q <= usc_pkg::STAT_OK;
				type_q   <= rd_type;
				index_q  <= hit_idx_ext[usc_pkg::INDEX_W-1:0];
			end else begin
				status_q <= usc_pkg::STAT_MISS;
				type_q   <= unknown_q;
				index_q  <= '0;
			end
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign type_code   = type_q;
	assign match_index = index_q;

endmodule

### rtl/core/usc_ctrl.sv
// ----------------------------------------------------------------------------
// usc_ctrl
// Request decode and lookup sequencing for the URL suffix type classifier.
// ----------------------------------------------------------------------------
module usc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     opcode,
	input  logic           char_is_last,
	input  usc_pkg::stat_t stat,
	output logic           busy,
	output usc_pkg::ctrl_t ctrl
);

	usc_pkg::state_t state_q;
	usc_pkg::state_t state_nxt;
	logic            accept;
	logic            url_end;

	assign accept  = start && (state_q == usc_pkg::ST_IDLE);
	assign url_end = (opcode == usc_pkg::OP_END) ||
		((opcode == usc_pkg::OP_CHAR) && char_is_last);

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= usc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			usc_pkg::ST_IDLE: begin
				if (accept && url_end) begin
					state_nxt = usc_pkg::ST_SCAN;
				end
			end
			usc_pkg::ST_SCAN: begin
				if (stat.hit || stat.exhausted) begin
					state_nxt = usc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = usc_pkg::ST_IDLE;
			end
		endcase
	end

	// Commands
	always_comb begin
		ctrl = '0;
		busy = 1'b0;
		case (state_q)
			usc_pkg::ST_IDLE: begin
				ctrl.add        = accept && (opcode == usc_pkg::OP_ADD);
				ctrl.clear      = accept && (opcode == usc_pkg::OP_CLEAR);
				ctrl.take_char  = accept && (opcode == usc_pkg::OP_CHAR);
				ctrl.begin_scan = accept && url_end;
			end
			usc_pkg::ST_SCAN: begin
				busy        = 1'b1;
				ctrl.issue  = stat.more && !stat.hit;
				ctrl.finish = stat.hit || stat.exhausted;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

### rtl/core/url_suffix_type_classifier_top.sv
// ----------------------------------------------------------------------------
// url_suffix_type_classifier_top
// Suffix table with streaming URL suffix tracking and case-blind lookup.
// ----------------------------------------------------------------------------
// Usage
//   A request is taken at a clock edge with start high and busy low. opcode
//   selects add entry, clear table, URL character or URL end; the other fields
//   are read only where the opcode needs them.
//   Results appear on status, type_code and match_index for exactly one cycle
//   with done high; the receiver cannot stall them.
//   Add, clear and a URL character that does not end the URL finish in the
//   cycle of acceptance; add and clear give a result on the next cycle, and a
//   new request may be taken in that same cycle.
//   A URL end walks the table one entry per cycle through the registered read
//   port of the entry memory: busy stays high until a hit, until all entries
//   have been examined on a miss, or until it is seen that no usable suffix
//   exists or the table is empty; done is high in the first cycle with busy
//   low again. The unknown code is written through cfg_valid/cfg_data
//   (cfg_ready is always high); the user must write it only while no request
//   is in flight, which the block itself does not enforce.
//   Reset empties the table, clears suffix tracking and sets the unknown code
//   to zero; table contents are not cleared.
// ----------------------------------------------------------------------------
module url_suffix_type_classifier_top #(
	parameter int TABLE_DEPTH = 16,
	parameter int KEY_CHARS   = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     opcode,
	input  logic [usc_pkg::CHAR_W-1:0]     url_char,
	input  logic                           char_is_last,
	input  logic [usc_pkg::KEY_PORT_W-1:0] entry_key,
	input  logic [usc_pkg::LEN_W-1:0]      entry_len,
	input  logic [usc_pkg::TYPE_W-1:0]     entry_type,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [usc_pkg::TYPE_W-1:0]     cfg_data,
	output logic                           done,
	output logic [usc_pkg::STATUS_W-1:0]   status,
	output logic [usc_pkg::TYPE_W-1:0]     type_code,
	output logic [usc_pkg::INDEX_W-1:0]    match_index
);

	usc_pkg::ctrl_t ctrl;
	usc_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	usc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.opcode       (opcode),
		.char_is_last (char_is_last),
		.stat         (stat),
		.busy         (busy),
		.ctrl         (ctrl)
	);

	usc_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_CHARS   (KEY_CHARS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.stat        (stat),
		.url_char    (url_char),
		.entry_key   (entry_key),
		.entry_len   (entry_len),
		.entry_type  (entry_type),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.done        (done),
		.status      (status),
		.type_code   (type_code),
		.match_index (match_index)
	);

endmodule

### rtl/core/usc_checker.sv
// ----------------------------------------------------------------------------
// usc_checker
// Port-level checks on request and result timing of the classifier.
// ----------------------------------------------------------------------------
module usc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [1:0]                   opcode,
	input logic                         char_is_last,
	input logic                         done,
	input logic [usc_pkg::STATUS_W-1:0] status,
	input logic [usc_pkg::TYPE_W-1:0]   type_code,
	input logic [usc_pkg::INDEX_W-1:0]  match_index
);

	// A result never shows while a lookup is still running
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// Add and clear answer on the next cycle
	a_add_clear_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (opcode == usc_pkg::OP_ADD || opcode == usc_pkg::OP_CLEAR))
		|=> done)
		else $error("missing add or clear result");

	// A URL character that does not end the URL gives no result
	a_char_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == usc_pkg::OP_CHAR && !char_is_last) |=> !done)
		else $error("unexpected result for mid-URL character");

	// Table full carries zero type and index
	a_full_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == usc_pkg::STAT_FULL) |-> (type_code == '0 && match_index == '0))
		else $error("table full result with non-zero payload");

	// A miss reports index zero
	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == usc_pkg::STAT_MISS) |-> (match_index == '0))
		else $error("miss result with non-zero index");

endmodule

bind url_suffix_type_classifier_top usc_checker u_usc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.opcode       (opcode),
	.char_is_last (char_is_last),
	.done         (done),
	.status       (status),
	.type_code    (type_code),
	.match_index  (match_index)
);
